FILE: rtl/bm3_pkg.sv
// shared types and register codes of the 3x3 binary morphology block
`default_nettype none

package bm3_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ERODE_MODE   = 2'd2;
  localparam logic [1:0] CFG_FILL_VALUE   = 2'd3;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic [31:0] FILL_VALUE_RST   = 32'h3F80_0000;

  // smallest meaningful image side
  localparam int MIN_SIDE = 3;

  // configuration register file contents
  typedef struct packed {
    logic [10:0] image_width;
    logic [15:0] image_height;
    logic        erode_mode;
    logic [31:0] fill_value;
  } cfg_t;

  // position tag of one pixel, carried alongside it to the window stage
  typedef struct packed {
    logic        has_out;
    logic        frame_last;
    logic [9:0]  col;
    logic [15:0] row;
  } pos_t;

endpackage

`default_nettype wire

FILE: rtl/bm3_line_mem.sv
// line store of zero flags: one write port, one registered read port
`default_nettype none

module bm3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [1:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/bm3_scan.sv
// raster position counters and tagging of each incoming pixel
`default_nettype none

module bm3_scan #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic [10:0]   image_width,
  input  wire logic [15:0]   image_height,
  output logic      [AW-1:0] addr,
  output bm3_pkg::pos_t      pos
);

  import bm3_pkg::*;

  localparam int EW = (CW > 11) ? CW : 11;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MINW = EW'(MIN_SIDE);
  localparam logic [15:0]   MINH = 16'(MIN_SIDE);

  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [EW-1:0] w_ext, eff_w, c_ext;
  logic [15:0]   eff_h;
  logic          col_wrap;
  logic [16:0]   row_inc;
  logic [CW-1:0] c;
  logic [15:0]   r;
  logic [CW-1:0] c_inc;
  logic          row_end;
  logic [16:0]   row_adv;

  // clamp geometry to its meaningful range
  always_comb begin
    w_ext = EW'(image_width);
    if (w_ext < MINW) begin
      eff_w = MINW;
    end else if (w_ext > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = w_ext;
    end
    eff_h = (image_height < MINH) ? MINH : image_height;
  end

  // wrap a counter that lies at or beyond the bound
  always_comb begin
    col_wrap = EW'(col_r) >= eff_w;
    row_inc  = {1'b0, row_r} + {16'd0, col_wrap};
    c        = col_wrap ? '0 : col_r;
    r        = (row_inc >= {1'b0, eff_h}) ? 16'd0 : row_inc[15:0];
    c_ext    = EW'(c);
  end

  // step to the next pixel, wrapping at the end of a row and of a frame
  always_comb begin
    c_inc   = c + CW'(1);
    row_end = EW'(c_inc) >= eff_w;
    row_adv = {1'b0, r} + 17'd1;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (row_adv >= {1'b0, eff_h}) ? 16'd0 : row_adv[15:0];
    end else begin
      col_nxt = c_inc;
      row_nxt = r;
    end
  end

  // tag of the current pixel
  always_comb begin
    addr           = c[AW-1:0];
    pos.has_out    = (c_ext >= EW'(2)) && (r >= 16'd2);
    pos.frame_last = (c_ext == eff_w - EW'(1)) && (r == eff_h - 16'd1);
    pos.col        = 10'(c_ext - EW'(1));
    pos.row        = r - 16'd1;
  end

  // position of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bm3_window.sv
// window stage: line store write-back, 3x3 flag window and output register
`default_nettype none

module bm3_window #(
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  output logic               in_ready,
  input  wire logic          in_zero,
  input  wire logic [AW-1:0] in_addr,
  input  wire bm3_pkg::pos_t in_pos,
  input  wire logic [1:0]    rd_data,
  output logic               wr_en,
  output logic      [AW-1:0] wr_addr,
  output logic      [1:0]    wr_data,
  input  wire logic          erode_mode,
  input  wire logic [31:0]   fill_value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic      [31:0]   out_value,
  output logic      [9:0]    out_col,
  output logic      [15:0]   out_row,
  output logic               out_frame_last
);

  import bm3_pkg::*;

  logic          s1_valid_r;
  logic          s1_zero_r;
  logic [AW-1:0] s1_addr_r;
  pos_t          s1_pos_r;
  logic          s1_adv;
  logic [8:0]    win_r, win_nxt;
  logic [2:0]    col3;
  logic [31:0]   value;

  logic          out_valid_r;
  logic [31:0]   out_value_r;
  logic [9:0]    out_col_r;
  logic [15:0]   out_row_r;
  logic          out_last_r;

  // stage moves when the output register is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // new window column: two rows up, one row up, current pixel
  always_comb begin
    col3    = {s1_zero_r, rd_data[0], rd_data[1]};
    win_nxt = {win_r[5:0], col3};
    if (erode_mode) begin
      value = (win_nxt == 9'h000) ? fill_value : 32'd0;
    end else begin
      value = (win_nxt == 9'h1FF) ? 32'd0 : fill_value;
    end
  end

  // write-back of the shifted flags; consecutive pixels never share an entry
  assign wr_en   = s1_adv;
  assign wr_addr = s1_addr_r;
  assign wr_data = {rd_data[0], s1_zero_r};

  // stage control and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        win_r <= win_nxt;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_zero_r <= in_zero;
      s1_addr_r <= in_addr;
      s1_pos_r  <= in_pos;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_pos_r.has_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos_r.has_out) begin
      out_value_r <= value;
      out_col_r   <= s1_pos_r.col;
      out_row_r   <= s1_pos_r.row;
      out_last_r  <= s1_pos_r.frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/binary_morphology_3x3.sv
// 3x3 binary dilation and erosion of a raster stream of float pixel words
//
// Usage: pixels enter on the in_ channel in raster order, one transfer per
// pixel. A pixel is zero when bits 30..0 are clear. Each interior pixel
// (not in the first or last row or column) yields one transfer on the out_
// channel with its column, row and a last flag on the final one of a frame;
// border pixels yield nothing. The result of the window centered one row up
// and one column left of an incoming pixel passes the window stage and output
// registers. Throughput is one pixel per cycle while the receiver does not
// stall, set by the single read and single write per cycle of the line flag
// memory. Configuration (width, height, erode mode, fill value) goes through
// the cfg_ channel, always ready, and is to be written by the user only while
// the block is idle; the block itself does not enforce this. Reset clears the
// position counters, the window and the pipeline valid bits; the line memory
// is not cleared, as each entry is written in a frame before its contents are
// used. When the receiver stalls, the output register holds its transfer, the
// window stage fills, and in_ready drops until the output register empties.
`default_nettype none

module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pixel_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_value,
  output logic      [9:0]  out_col,
  output logic      [15:0] out_row,
  output logic             out_frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import bm3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  cfg_t          cfg_r;
  logic          in_fire;
  logic          in_zero;
  logic [AW-1:0] scan_addr;
  pos_t          scan_pos;
  logic [1:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_zero   = (in_pixel_bits[30:0] == 31'd0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= IMAGE_WIDTH_RST;
      cfg_r.image_height <= IMAGE_HEIGHT_RST;
      cfg_r.erode_mode   <= 1'b0;
      cfg_r.fill_value   <= FILL_VALUE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[15:0];
        CFG_ERODE_MODE:   cfg_r.erode_mode   <= cfg_data[0];
        CFG_FILL_VALUE:   cfg_r.fill_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  // position of each accepted pixel
  bm3_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_fire),
    .image_width  (cfg_r.image_width),
    .image_height (cfg_r.image_height),
    .addr         (scan_addr),
    .pos          (scan_pos)
  );

  // line flag memory, read on transfer, written back by the window stage
  bm3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (scan_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // window and output stage
  bm3_window #(
    .AW (AW)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_ready       (in_ready),
    .in_zero        (in_zero),
    .in_addr        (scan_addr),
    .in_pos         (scan_pos),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .erode_mode     (cfg_r.erode_mode),
    .fill_value     (cfg_r.fill_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench of the 3x3 binary dilation and erosion block
module testbench;
  import bm3_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 5000;
  localparam int RANDOM_PIXELS = 1350;
  localparam int BACKLOG_HOLD  = 300;
  localparam int FRAME_WIDTH   = 128;

  // one window result as it leaves the block
  typedef struct packed {
    logic [31:0] value;
    logic [9:0]  col;
    logic [15:0] row;
    logic        last;
  } morph_result_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [31:0] in_pixel_bits = '0;
  logic        out_ready     = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic [1:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_value;
  logic [9:0]  out_col;
  logic [15:0] out_row;
  logic        out_frame_last;
  logic        cfg_ready;

  // shadow of the block's registers and zero-flag state
  logic [10:0] model_width;
  logic [15:0] model_height;
  logic        model_erode;
  logic [31:0] model_fill;
  logic [1:0]  zero_history [0:MAX_WIDTH-1];
  logic [8:0]  zero_window;
  int          pos_col;
  int          pos_row;
  int          cols_seen;
  int          cols_written;

  logic [31:0]   pixel_stream [$];
  morph_result_t results_due [$];

  int n_queued     = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_frames     = 0;
  int n_reg_writes = 0;
  int n_errors     = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;
  bit gaps_on         = 1'b0;
  bit stalls_on       = 1'b0;
  bit backlog_request = 1'b0;

  binary_morphology_3x3 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_bits  (in_pixel_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_width(input int w);
    if (w < MIN_SIDE) return MIN_SIDE;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic int clamp_height(input int h);
    return (h < MIN_SIDE) ? MIN_SIDE : h;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // pixel word, zero (either sign) with the given percentage
  function automatic logic [31:0] gen_pixel(input int zero_pct);
    logic [31:0] px;
    if ($urandom_range(99) < zero_pct) begin
      px = 32'd0;
      px[31] = 1'($urandom_range(1));
    end else begin
      if ($urandom_range(3) == 0) begin
        px = 32'd1 << $urandom_range(30);
        px[31] = 1'($urandom_range(1));
      end else begin
        px = $urandom();
      end
      if (px[30:0] == 31'd0) px[0] = 1'b1;
    end
    return px;
  endfunction

  // advance the window by one accepted pixel and record any interior result
  task automatic step_morphology(input logic [31:0] px);
    int            w;
    int            h;
    int            tmp;
    logic          z;
    logic [1:0]    hist;
    logic [2:0]    col3;
    morph_result_t res;
    w = clamp_width(model_width);
    h = clamp_height(model_height);
    // a shrunk geometry wraps the counters before the pixel is placed
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    z = (px[30:0] == 31'd0);
    hist = zero_history[pos_col];
    col3 = {z, hist[0], hist[1]};
    zero_history[pos_col] = {hist[0], z};
    zero_window = {zero_window[5:0], col3};
    if (pos_col >= 2 && pos_row >= 2) begin
      if (model_erode) res.value = (zero_window == 9'h000) ? model_fill : 32'd0;
      else res.value = (zero_window == 9'h1FF) ? 32'd0 : model_fill;
      tmp = pos_col - 1;
      res.col = tmp[9:0];
      tmp = pos_row - 1;
      res.row = tmp[15:0];
      res.last = (pos_col == w - 1) && (pos_row == h - 1);
      results_due.push_back(res);
    end
    // an entry holds both flags only from its second write on
    if (pos_col < cols_seen && pos_col + 1 > cols_written) cols_written = pos_col + 1;
    if (pos_col + 1 > cols_seen) cols_seen = pos_col + 1;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // pixel sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        step_morphology(in_pixel_bits);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_stream.size() != 0) begin
          in_valid <= 1'b1;
          in_pixel_bits <= pixel_stream.pop_front();
          send_gap = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin : result_check
    morph_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h col %0d row %0d last %0b",
                   $time, out_value, out_col, out_row, out_frame_last);
          n_errors++;
        end else begin
          want = results_due.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: out_value expected %h actual %h", $time, want.value, out_value);
            n_errors++;
          end
          if (out_col !== want.col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_col);
            n_errors++;
          end
          if (out_row !== want.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_row);
            n_errors++;
          end
          if (out_frame_last !== want.last) begin
            $display("%0t: out_frame_last expected %0b actual %0b", $time, want.last,
                     out_frame_last);
            n_errors++;
          end
          n_checked++;
          if (want.last) n_frames++;
        end
      end
      // long hold-off once a result waits, so the block backs up into its input
      if (backlog_request && out_valid) begin
        backlog_request = 1'b0;
        stall_left = BACKLOG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on && $urandom_range(99) < 30) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, results_due.size());
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register write transfer, mirrored into the shadow registers
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  model_width = data[10:0];
      CFG_IMAGE_HEIGHT: model_height = data[15:0];
      CFG_ERODE_MODE:   model_erode = data[0];
      CFG_FILL_VALUE:   model_fill = data;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic queue_word(input logic [31:0] px);
    pixel_stream.push_back(px);
    n_queued++;
  endtask

  task automatic queue_pixels(input int n, input int zero_pct);
    for (int i = 0; i < n; i++) queue_word(gen_pixel(zero_pct));
  endtask

  // wait for all pixels taken and all results back, then let trailing border pixels settle
  task automatic drain();
    while (pixel_stream.size() != 0 || n_accepted != n_queued || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random configuration followed by a burst of pixels
  task automatic random_phase(output int n);
    logic [31:0] data;
    int          new_w;
    int          pick;
    int          zero_pct;
    bit          wrote;
    wrote = 1'b0;
    // width grows mid-frame only over columns whose flags are fully written
    if ($urandom_range(99) < 50) begin
      pick = $urandom_range(99);
      if (pick < 8) new_w = $urandom_range(2);
      else if (pick < 14) new_w = $urandom_range(2047, 1025);
      else if (pick < 30) new_w = $urandom_range(40, 17);
      else new_w = $urandom_range(16, 3);
      if ((pos_col == 0 && pos_row == 0) || clamp_width(new_w) <= cols_written) begin
        data = $urandom();
        data[10:0] = 11'(new_w);
        write_reg(CFG_IMAGE_WIDTH, data);
        wrote = 1'b1;
      end
    end
    if ($urandom_range(99) < 50) begin
      pick = $urandom_range(99);
      data = $urandom();
      if (pick < 8) data[15:0] = 16'($urandom_range(2));
      else if (pick >= 20) data[15:0] = 16'($urandom_range(8, 3));
      write_reg(CFG_IMAGE_HEIGHT, data);
      wrote = 1'b1;
    end
    if ($urandom_range(99) < 50) begin
      write_reg(CFG_FILL_VALUE, ($urandom_range(9) == 0) ? 32'd0 :
                                ($urandom_range(8) == 0) ? 32'hFFFF_FFFF : $urandom());
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(99) < 50) write_reg(CFG_ERODE_MODE, $urandom());
    gaps_on = ($urandom_range(99) < 80);
    stalls_on = ($urandom_range(99) < 80);
    if ($urandom_range(99) < 10) backlog_request = 1'b1;
    case ($urandom_range(3))
      0: zero_pct = 3;
      1: zero_pct = 30;
      2: zero_pct = 70;
      default: zero_pct = 97;
    endcase
    if ($urandom_range(99) < 60) begin
      n = clamp_width(model_width) * clamp_height(model_height) * $urandom_range(3, 1);
      if (n > 400) n = $urandom_range(300, 50);
    end else begin
      n = $urandom_range(120, 5);
    end
    queue_pixels(n, zero_pct);
    drain();
  endtask

  // stimulus sequence
  initial begin
    int random_total;
    int n;
    model_width = IMAGE_WIDTH_RST;
    model_height = IMAGE_HEIGHT_RST;
    model_erode = 1'b0;
    model_fill = FILL_VALUE_RST;
    for (int i = 0; i < MAX_WIDTH; i++) zero_history[i] = 2'b00;
    zero_window = '0;
    pos_col = 0;
    pos_row = 0;
    cols_seen = 0;
    cols_written = 0;
    random_total = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // undersized geometry acts as 3x3; dilation with a lone nonzero center
    write_reg(CFG_IMAGE_WIDTH, 32'd0);
    write_reg(CFG_IMAGE_HEIGHT, 32'd2);
    write_reg(CFG_ERODE_MODE, 32'd0);
    write_reg(CFG_FILL_VALUE, 32'hFFFF_FFFF);
    queue_word(32'h0000_0000); queue_word(32'h8000_0000); queue_word(32'h0000_0000);
    queue_word(32'h0000_0000); queue_word(32'h0000_0001); queue_word(32'h0000_0000);
    queue_word(32'h8000_0000); queue_word(32'h0000_0000); queue_word(32'h0000_0000);
    drain();

    // erosion over nonzero words: negative, infinities, nan
    write_reg(CFG_ERODE_MODE, 32'd1);
    write_reg(CFG_FILL_VALUE, 32'h7FC0_0000);
    queue_word(32'hFFFF_FFFF); queue_word(32'h7FFF_FFFF); queue_word(32'h7F80_0000);
    queue_word(32'h7FC0_0000); queue_word(32'h0000_0001); queue_word(32'h8000_0001);
    queue_word(32'h4000_0000); queue_word(32'hFF80_0000); queue_word(32'h3F80_0000);
    drain();

    // oversized width and tallest frame, part of the first row only
    write_reg(CFG_IMAGE_WIDTH, 32'h0000_07FF);
    write_reg(CFG_IMAGE_HEIGHT, 32'h0000_FFFF);
    queue_pixels(4, 50);
    drain();

    // shrink geometry and switch mode mid-frame, column wraps into the next row
    write_reg(CFG_IMAGE_WIDTH, 32'd0);
    write_reg(CFG_IMAGE_HEIGHT, 32'd0);
    write_reg(CFG_ERODE_MODE, 32'd0);
    write_reg(CFG_FILL_VALUE, 32'h8000_0000);
    queue_pixels(6, 50);
    drain();

    // one full frame with wide rows, with a long receiver hold-off
    write_reg(CFG_IMAGE_WIDTH, 32'(FRAME_WIDTH));
    write_reg(CFG_IMAGE_HEIGHT, 32'd3);
    write_reg(CFG_FILL_VALUE, 32'h3F80_0000);
    backlog_request = 1'b1;
    queue_pixels(3 * FRAME_WIDTH, 90);
    drain();

    // random configurations and pixel bursts
    while (random_total < RANDOM_PIXELS) begin
      random_phase(n);
      random_total += n;
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d pixels, %0d window results, %0d complete frames, %0d reg writes",
             n_accepted, n_checked, n_frames, n_reg_writes);
    $display("dilation and erosion across varied geometry, %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
